/* sv/pnrf_pkg.sv */
package pnrf_pkg;

   localparam int MAX_WIDTH_DEF    = 256;
   localparam int MAX_HEIGHT_DEF   = 256;
   localparam int CHANNEL_BITS_DEF = 16;

   localparam int FIELD_BITS     = 16;
   localparam int COORD_BITS     = 8;
   localparam int DIM_BITS       = 9;
   localparam int BYTE_BITS      = 8;
   localparam int WORD_BITS      = 32;
   localparam int DIVIDEND_BITS  = FIELD_BITS + BYTE_BITS;
   localparam int DIV_STEPS      = 8;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 9;

   localparam logic [BYTE_BITS-1:0] ALPHA_BYTE = 8'hFF;
   localparam logic [BYTE_BITS-1:0] FULL_BYTE  = 8'hFF;

   localparam logic [DIM_BITS-1:0] SIZE_RESET = 9'd256;

   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_PEAK  = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   localparam logic [1:0] KIND_PIXEL = 2'd0;
   localparam logic [1:0] KIND_PEAK  = 2'd1;
   localparam logic [1:0] KIND_RANGE = 2'd2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ORDER  = 2'd2;

   localparam logic [1:0] CH_RED   = 2'd0;
   localparam logic [1:0] CH_GREEN = 2'd1;
   localparam logic [1:0] CH_BLUE  = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FETCH,
      ST_CONV,
      ST_WAIT,
      ST_PEAK,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic                  start;
      logic [FIELD_BITS-1:0] value;
      logic [FIELD_BITS-1:0] peak;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [BYTE_BITS-1:0] quotient;
   } div_rsp_type;

endpackage

/* sv/pnrf_store.sv */
module pnrf_store #(
   parameter int DEPTH  = pnrf_pkg::MAX_WIDTH_DEF * pnrf_pkg::MAX_HEIGHT_DEF,
   parameter int ADDR_W = $clog2(pnrf_pkg::MAX_WIDTH_DEF * pnrf_pkg::MAX_HEIGHT_DEF),
   parameter int DATA_W = 3 * pnrf_pkg::CHANNEL_BITS_DEF
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/pnrf_divider.sv */
module pnrf_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  pnrf_pkg::div_req_type div_req,
   output pnrf_pkg::div_rsp_type div_rsp
);

   import pnrf_pkg::*;

   localparam int CNT_BITS = $clog2(DIV_STEPS);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [CNT_BITS-1:0]      cnt_ff, cnt_in;
   logic [FIELD_BITS-1:0]    rem_ff, rem_in;
   logic [FIELD_BITS-1:0]    divisor_ff, divisor_in;
   logic [BYTE_BITS-1:0]     low_ff, low_in;
   logic [BYTE_BITS-1:0]     quot_ff, quot_in;
   logic [DIVIDEND_BITS-1:0] dividend;
   logic [FIELD_BITS:0]      trial;
   logic [FIELD_BITS:0]      diff;
   logic                     fits;

   // value * 255 as (value << 8) - value.
   assign dividend = {div_req.value, {BYTE_BITS{1'b0}}}
                   - {{BYTE_BITS{1'b0}}, div_req.value};

   assign trial = {rem_ff, low_ff[BYTE_BITS-1]};
   assign diff  = trial - {1'b0, divisor_ff};
   assign fits  = (trial >= {1'b0, divisor_ff});

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      low_in     = low_ff;
      quot_in    = quot_ff;
      if (div_req.start) begin
         if (div_req.peak == '0) begin
            quot_in = '0;
            done_in = 1'b1;
            busy_in = 1'b0;
         end else if (div_req.value >= div_req.peak) begin
            // The quotient would be 255 or more, so the byte saturates.
            quot_in = FULL_BYTE;
            done_in = 1'b1;
            busy_in = 1'b0;
         end else begin
            // Below the peak the quotient fits in one byte, so the upper
            // dividend bits already form a remainder below the divisor.
            rem_in     = dividend[DIVIDEND_BITS-1:BYTE_BITS];
            low_in     = dividend[BYTE_BITS-1:0];
            divisor_in = div_req.peak;
            cnt_in     = CNT_BITS'(DIV_STEPS - 1);
            busy_in    = 1'b1;
         end
      end else if (busy_ff) begin
         rem_in  = fits ? diff[FIELD_BITS-1:0] : trial[FIELD_BITS-1:0];
         low_in  = {low_ff[BYTE_BITS-2:0], 1'b0};
         quot_in = {quot_ff[BYTE_BITS-2:0], fits};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff     <= cnt_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      low_ff     <= low_in;
      quot_ff    <= quot_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quot_ff;

endmodule

/* sv/peak_normalize_rgb_frame.sv */
// Write: no result beat when in range. Out-of-range write or read: a range result beat.
// Read: the result beat follows three passes through the shared 8-step divider, one
// per channel; a pass skips the division when the peak is zero or reached.
// Peak: one frame store read per pixel through its single read port.
// One item at a time; the next item is taken while a result beat still waits.
// Reset (synchronous): a clearing pass zeroes all MAX_WIDTH*MAX_HEIGHT store entries first.
module peak_normalize_rgb_frame #(
   parameter int MAX_WIDTH    = pnrf_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT   = pnrf_pkg::MAX_HEIGHT_DEF,
   parameter int CHANNEL_BITS = pnrf_pkg::CHANNEL_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [1:0]                            req_operation,
   input  logic [pnrf_pkg::COORD_BITS-1:0]       req_column,
   input  logic [pnrf_pkg::COORD_BITS-1:0]       req_row,
   input  logic [pnrf_pkg::FIELD_BITS-1:0]       req_red_value,
   input  logic [pnrf_pkg::FIELD_BITS-1:0]       req_green_value,
   input  logic [pnrf_pkg::FIELD_BITS-1:0]       req_blue_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [1:0]                            rsp_result_kind,
   output logic [pnrf_pkg::WORD_BITS-1:0]        rsp_pixel_word,
   output logic [pnrf_pkg::FIELD_BITS-1:0]       rsp_linear_index,
   output logic [pnrf_pkg::FIELD_BITS-1:0]       rsp_peak_value,
   input  logic                                  csr_wen,
   input  logic [pnrf_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [pnrf_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   import pnrf_pkg::*;

   localparam int STORE_BITS = (CHANNEL_BITS < FIELD_BITS) ? CHANNEL_BITS : FIELD_BITS;
   localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int DATA_W     = 3 * STORE_BITS;

   state_type state_ff, state_in;

   logic [DIM_BITS-1:0]   width_ff, height_ff;
   logic                  order_ff;
   logic [DIM_BITS-1:0]   width_eff, height_eff;

   logic                  req_accept;
   logic                  in_range;
   logic                  size_zero;
   logic [ADDR_W-1:0]     req_addr;
   logic [FIELD_BITS:0]   req_index_full;

   logic [ADDR_W-1:0]     clr_addr_ff, clr_addr_in;
   logic                  clr_last;

   logic [DIM_BITS-1:0]   col_ff, col_in;
   logic [DIM_BITS-1:0]   row_ff, row_in;
   logic [ADDR_W-1:0]     base_ff, base_in;
   logic                  walk_last;
   logic                  rd_vld_ff, rd_vld_in;
   logic [FIELD_BITS-1:0] pk_ff, pk_in, pk_upd;
   logic [FIELD_BITS-1:0] peak_ff, peak_in;

   logic [DATA_W-1:0]     pix_ff, pix_in;
   logic [1:0]            ch_ff, ch_in;
   logic [BYTE_BITS-1:0]  red_byte_ff, red_byte_in;
   logic [BYTE_BITS-1:0]  green_byte_ff, green_byte_in;
   logic [BYTE_BITS-1:0]  blue_byte_ff, blue_byte_in;
   logic [1:0]            kind_ff, kind_in;
   logic [FIELD_BITS-1:0] index_ff, index_in;

   logic                  out_free;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            rsp_kind_ff, rsp_kind_in;
   logic [WORD_BITS-1:0]  rsp_word_ff, rsp_word_in;
   logic [FIELD_BITS-1:0] rsp_index_ff, rsp_index_in;
   logic [FIELD_BITS-1:0] rsp_peak_ff, rsp_peak_in;
   logic [WORD_BITS-1:0]  packed_word;

   logic                  st_wr_en;
   logic [ADDR_W-1:0]     st_wr_addr;
   logic [DATA_W-1:0]     st_wr_data;
   logic [ADDR_W-1:0]     st_rd_addr;
   logic [DATA_W-1:0]     st_rd_data;

   logic [FIELD_BITS-1:0] rd_red, rd_green, rd_blue;
   logic [FIELD_BITS-1:0] pix_red, pix_green, pix_blue;
   logic [FIELD_BITS-1:0] max_rg, max_bp;

   div_req_type div_req;
   div_rsp_type div_rsp;

   // Sizes beyond the store act as the store's size.
   assign width_eff  = (32'(width_ff) > MAX_WIDTH) ? DIM_BITS'(MAX_WIDTH) : width_ff;
   assign height_eff = (32'(height_ff) > MAX_HEIGHT) ? DIM_BITS'(MAX_HEIGHT) : height_ff;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign in_range   = ({1'b0, req_column} < width_eff) && ({1'b0, req_row} < height_eff);
   assign size_zero  = (width_eff == '0) || (height_eff == '0);
   assign req_addr   = ADDR_W'(32'(req_row) * MAX_WIDTH + 32'(req_column));
   assign req_index_full = {{(FIELD_BITS-COORD_BITS+1){1'b0}}, req_row}
                         * {{(FIELD_BITS-DIM_BITS+1){1'b0}}, width_eff}
                         + {{(FIELD_BITS-COORD_BITS+1){1'b0}}, req_column};

   assign clr_last  = (clr_addr_ff == ADDR_W'(DEPTH - 1));
   assign walk_last = (col_ff == width_eff - 1'b1) && (row_ff == height_eff - 1'b1);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign rd_red    = FIELD_BITS'(st_rd_data[3*STORE_BITS-1:2*STORE_BITS]);
   assign rd_green  = FIELD_BITS'(st_rd_data[2*STORE_BITS-1:STORE_BITS]);
   assign rd_blue   = FIELD_BITS'(st_rd_data[STORE_BITS-1:0]);
   assign pix_red   = FIELD_BITS'(pix_ff[3*STORE_BITS-1:2*STORE_BITS]);
   assign pix_green = FIELD_BITS'(pix_ff[2*STORE_BITS-1:STORE_BITS]);
   assign pix_blue  = FIELD_BITS'(pix_ff[STORE_BITS-1:0]);

   assign max_rg = (rd_red > rd_green) ? rd_red : rd_green;
   assign max_bp = (rd_blue > pk_ff) ? rd_blue : pk_ff;
   assign pk_upd = rd_vld_ff ? ((max_rg > max_bp) ? max_rg : max_bp) : pk_ff;

   assign packed_word = order_ff ? {red_byte_ff, green_byte_ff, blue_byte_ff, ALPHA_BYTE}
                                 : {ALPHA_BYTE, blue_byte_ff, green_byte_ff, red_byte_ff};

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               case (req_operation)
                  OP_WRITE: state_in = in_range ? ST_IDLE : ST_EMIT;
                  OP_PEAK:  state_in = size_zero ? ST_EMIT : ST_PEAK;
                  OP_READ:  state_in = in_range ? ST_FETCH : ST_EMIT;
                  default:  state_in = ST_IDLE;
               endcase
            end
         end
         ST_FETCH: state_in = ST_CONV;
         ST_CONV:  state_in = ST_WAIT;
         ST_WAIT: begin
            if (div_rsp.done) begin
               state_in = (ch_ff == CH_BLUE) ? ST_EMIT : ST_CONV;
            end
         end
         ST_PEAK: begin
            if (walk_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_EMIT;
         ST_EMIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and store control.
   always_comb begin
      clr_addr_in   = clr_addr_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      base_in       = base_ff;
      rd_vld_in     = 1'b0;
      pk_in         = pk_upd;
      peak_in       = peak_ff;
      pix_in        = pix_ff;
      ch_in         = ch_ff;
      red_byte_in   = red_byte_ff;
      green_byte_in = green_byte_ff;
      blue_byte_in  = blue_byte_ff;
      kind_in       = kind_ff;
      index_in      = index_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_kind_in   = rsp_kind_ff;
      rsp_word_in   = rsp_word_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_peak_in   = rsp_peak_ff;
      st_wr_en      = 1'b0;
      st_wr_addr    = req_addr;
      st_wr_data    = {STORE_BITS'(req_red_value), STORE_BITS'(req_green_value),
                       STORE_BITS'(req_blue_value)};
      st_rd_addr    = req_addr;
      div_req.start = 1'b0;
      div_req.peak  = peak_ff;
      case (ch_ff)
         CH_RED:   div_req.value = pix_red;
         CH_GREEN: div_req.value = pix_green;
         default:  div_req.value = pix_blue;
      endcase

      unique case (state_ff)
         ST_CLEAR: begin
            st_wr_en    = 1'b1;
            st_wr_addr  = clr_addr_ff;
            st_wr_data  = '0;
            clr_addr_in = clr_addr_ff + 1'b1;
         end
         ST_IDLE: begin
            if (req_accept) begin
               index_in = '0;
               kind_in  = KIND_RANGE;
               col_in   = '0;
               row_in   = '0;
               base_in  = '0;
               pk_in    = '0;
               case (req_operation)
                  OP_WRITE: st_wr_en = in_range;
                  OP_PEAK: begin
                     kind_in = KIND_PEAK;
                     if (size_zero) begin
                        peak_in = '0;
                     end
                  end
                  OP_READ: begin
                     if (in_range) begin
                        kind_in  = KIND_PIXEL;
                        index_in = req_index_full[FIELD_BITS-1:0];
                     end
                  end
                  default: kind_in = kind_ff;
               endcase
            end
         end
         ST_FETCH: begin
            pix_in = st_rd_data;
            ch_in  = CH_RED;
         end
         ST_CONV: begin
            div_req.start = 1'b1;
         end
         ST_WAIT: begin
            if (div_rsp.done) begin
               case (ch_ff)
                  CH_RED:   red_byte_in   = div_rsp.quotient;
                  CH_GREEN: green_byte_in = div_rsp.quotient;
                  default:  blue_byte_in  = div_rsp.quotient;
               endcase
               ch_in = ch_ff + 1'b1;
            end
         end
         ST_PEAK: begin
            // Issue one read per cycle; each compare uses the registered read data in the next cycle.
            st_rd_addr = base_ff + ADDR_W'(col_ff);
            rd_vld_in  = 1'b1;
            if (col_ff == width_eff - 1'b1) begin
               col_in  = '0;
               row_in  = row_ff + 1'b1;
               base_in = base_ff + ADDR_W'(MAX_WIDTH);
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            peak_in = pk_upd;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = kind_ff;
               rsp_word_in  = (kind_ff == KIND_PIXEL) ? packed_word : '0;
               rsp_index_in = index_ff;
               rsp_peak_in  = peak_ff;
            end
         end
         default: begin
            st_wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         rd_vld_ff    <= 1'b0;
         peak_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         width_ff     <= SIZE_RESET;
         height_ff    <= SIZE_RESET;
         order_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rd_vld_ff    <= rd_vld_in;
         peak_ff      <= peak_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wen) begin
            unique case (csr_index)
               CSR_WIDTH:  width_ff  <= csr_wdata;
               CSR_HEIGHT: height_ff <= csr_wdata;
               CSR_ORDER:  order_ff  <= csr_wdata[0];
               default:    order_ff  <= order_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      col_ff        <= col_in;
      row_ff        <= row_in;
      base_ff       <= base_in;
      pk_ff         <= pk_in;
      pix_ff        <= pix_in;
      ch_ff         <= ch_in;
      red_byte_ff   <= red_byte_in;
      green_byte_ff <= green_byte_in;
      blue_byte_ff  <= blue_byte_in;
      kind_ff       <= kind_in;
      index_ff      <= index_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_word_ff   <= rsp_word_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_peak_ff   <= rsp_peak_in;
   end

   pnrf_store #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W),
      .DATA_W (DATA_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (st_wr_addr),
      .wr_data (st_wr_data),
      .rd_addr (st_rd_addr),
      .rd_data (st_rd_data)
   );

   pnrf_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_kind  = rsp_kind_ff;
   assign rsp_pixel_word   = rsp_word_ff;
   assign rsp_linear_index = rsp_index_ff;
   assign rsp_peak_value   = rsp_peak_ff;

endmodule
